// ----- rtl/oriented_rect_collision_test_unit_macros.svh -----
// Assertion macros shared by the collision test unit.
`ifndef ORIENTED_RECT_COLLISION_TEST_UNIT_MACROS_SVH
`define ORIENTED_RECT_COLLISION_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ORCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("orct: same-cycle check failed");
`define ORCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("orct: next-cycle check failed");
`else
`define ORCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define ORCT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/orct_pkg.sv -----
package orct_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int SIN_LAT        = 11;
   localparam int PIPE_DEPTH     = SIN_LAT + 8;

   typedef logic signed [15:0] trig_type;

   typedef struct packed {
      trig_type x;
      trig_type y;
   } axis_type;

   typedef struct packed {
      logic signed [31:0] pax;
      logic signed [31:0] pay;
      logic [30:0]        hwa;
      logic [30:0]        hha;
      logic [30:0]        hwb;
      logic [30:0]        hhb;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } box_type;

   function automatic logic [31:0] sin_coef(input logic [2:0] idx);
      logic [31:0] c;
      case (idx)
         3'd0: c = 32'd3373259426;
         3'd1: c = 32'd1387197336;
         3'd2: c = 32'd171138612;
         3'd3: c = 32'd10053990;
         3'd4: c = 32'd344545;
         3'd5: c = 32'd7728;
         3'd6: c = 32'd122;
         default: c = 32'd1;
      endcase
      return c;
   endfunction

   // Product scaled down by the trig fraction, rounded half away from zero.
   function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
      logic [63:0] m;
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic trig_type to_q14(input trig_type v);
      logic [31:0] m;
      m = v[15] ? 32'(-32'(v)) : 32'(32'(v));
      if (TRIG_FRAC_BITS > 14) begin
         m = (m + (32'd1 << (TRIG_FRAC_BITS - 15))) >> (TRIG_FRAC_BITS - 14);
      end else begin
         m = m << (14 - TRIG_FRAC_BITS);
      end
      return v[15] ? trig_type'(-$signed(m[15:0])) : trig_type'(m[15:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/orct_sin.sv -----
module orct_sin (
   input  logic              clock,
   input  logic              enable,
   input  logic [15:0]       angle,
   output orct_pkg::trig_type sin_out
);

   localparam int QB = orct_pkg::ANGLE_BITS - 2;
   localparam int FB = orct_pkg::TRIG_FRAC_BITS;

   logic [31:0] t_in;
   logic [31:0] t_ff [0:8];
   logic [1:0]  q_ff [0:9];
   logic [63:0] uprod;
   logic [31:0] u_ff [1:7];
   logic [31:0] p_in [2:8];
   logic [31:0] p_ff [2:8];
   logic [63:0] sprod;
   logic [31:0] s_ff;
   logic [32:0] vsum;
   logic [32:0] vmag;
   logic [15:0] vclip;
   orct_pkg::trig_type v_in;
   orct_pkg::trig_type v_ff;

   always_comb begin
      t_in = 32'(angle[QB-1:0]) << (33 - orct_pkg::ANGLE_BITS);
      if (angle[QB]) begin
         t_in = 32'h8000_0000 - t_in;
      end
   end

   assign uprod = 64'(t_ff[0]) * 64'(t_ff[0]);

   for (genvar s = 2; s <= 8; s++) begin : g_horner
      logic [63:0] hp;
      if (s == 2) begin : g_first
         assign hp = 64'(u_ff[s-1]) * 64'(orct_pkg::sin_coef(3'd7));
      end else begin : g_rest
         assign hp = 64'(u_ff[s-1]) * 64'(p_ff[s-1]);
      end
      assign p_in[s] = 32'(33'(orct_pkg::sin_coef(3'(8 - s))) - hp[63:31]);
   end

   assign sprod = 64'(t_ff[8]) * 64'(p_ff[8]);

   always_comb begin
      vsum  = 33'(s_ff) + (33'd1 << (30 - FB));
      vmag  = vsum >> (31 - FB);
      vclip = (vmag > (33'd1 << FB)) ? 16'(33'd1 << FB) : vmag[15:0];
      v_in  = q_ff[9][1] ? -$signed(vclip) : $signed(vclip);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff[0] <= t_in;
         q_ff[0] <= angle[QB+1:QB];
         for (int i = 1; i <= 8; i++) begin
            t_ff[i] <= t_ff[i-1];
         end
         for (int i = 1; i <= 9; i++) begin
            q_ff[i] <= q_ff[i-1];
         end
         u_ff[1] <= uprod[62:31];
         for (int i = 2; i <= 7; i++) begin
            u_ff[i] <= u_ff[i-1];
         end
         for (int i = 2; i <= 8; i++) begin
            p_ff[i] <= p_in[i];
         end
         s_ff <= sprod[62:31];
         v_ff <= v_in;
      end
   end

   assign sin_out = v_ff;

endmodule

// ----- rtl/oriented_rect_collision_test_unit.sv -----
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  req_tdata: box pair A and B
// rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata: normal, depth, corner; rsp_tuser: hit
// One item is accepted per cycle while the output is not stalled.
// The sine units take eleven stages (quadrant fold, square, seven Horner steps,
// final product and rounding), followed by eight stages of projection, overlap,
// axis selection and contact corner.
// Reset clears the valid bits only. A stalled output holds every stage.
`include "oriented_rect_collision_test_unit_macros.svh"

module oriented_rect_collision_test_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a_x, pos_a_y, angle_a, half_width_a, half_height_a,
   // pos_b_x, pos_b_y, angle_b, half_width_b, half_height_b, zero fill
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, penetration, contact_x, contact_y, zero fill
   output logic [135:0] rsp_tdata,
   // hit
   output logic         rsp_tuser
);

   localparam int LAST = orct_pkg::PIPE_DEPTH - 1;
   localparam int SL   = orct_pkg::SIN_LAT;

   logic adv;
   logic vld_ff [0:LAST];
   orct_pkg::box_type box_in;
   orct_pkg::box_type box_ff [0:SL+5];
   logic [15:0] quarter;
   orct_pkg::trig_type sa, ca, sb, cb;
   orct_pkg::axis_type ax_in [0:3];
   orct_pkg::axis_type ax_ff [SL:SL+5][0:3];

   logic signed [31:0] ppx_ff [0:3][0:3];
   logic signed [31:0] ppy_ff [0:3][0:3];
   logic signed [48:0] pdx_ff [0:3];
   logic signed [48:0] pdy_ff [0:3];

   logic signed [17:0] dd_ff [0:3][0:3];
   logic signed [35:0] ddf_ff [0:3];

   logic [47:0]        ht_ff [0:3][0:3];
   logic [34:0]        adf_h_ff [0:3];
   logic               neg_h_ff [0:3];
   logic signed [17:0] d0_h_ff [0:3];
   logic signed [17:0] d1_h_ff [0:3];

   logic [33:0]        rt_ff [0:3][0:3];
   logic [34:0]        adf_r_ff [0:3];
   logic               neg_r_ff [0:3];
   logic signed [17:0] d0_r_ff [0:3];
   logic signed [17:0] d1_r_ff [0:3];

   logic signed [37:0] ov_ff [0:3];
   logic               neg_o_ff [0:3];
   logic signed [17:0] d0_o_ff [0:3];
   logic signed [17:0] d1_o_ff [0:3];

   logic               hit_in;
   logic [1:0]         i01, i23, bi_in;
   logic signed [37:0] b01, b23, best_in;
   logic               flip_in, expos_in, eypos_in;
   logic               hit_s_ff, flip_s_ff, expos_s_ff, eypos_s_ff;
   logic [1:0]         bi_s_ff;
   logic signed [37:0] best_s_ff;

   orct_pkg::axis_type nrm;
   orct_pkg::trig_type nx_in, ny_in;
   logic [32:0]        pen_in;
   logic signed [31:0] ex, ey;
   logic               hit_c_ff;
   orct_pkg::trig_type nx_c_ff, ny_c_ff;
   logic [32:0]        pen_c_ff;
   logic signed [31:0] pax_c_ff, pay_c_ff;
   logic signed [47:0] cx0_ff, cx1_ff, cy0_ff, cy1_ff;

   logic signed [31:0] cx_in, cy_in;
   logic               hit_out_ff;
   orct_pkg::trig_type nx_out_ff, ny_out_ff;
   logic [32:0]        pen_out_ff;
   logic signed [31:0] cx_out_ff, cy_out_ff;

   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign quarter    = 16'(1 << (orct_pkg::ANGLE_BITS - 2));

   always_comb begin
      box_in.pax = $signed(req_tdata[31:0]);
      box_in.pay = $signed(req_tdata[63:32]);
      box_in.hwa = req_tdata[110:80];
      box_in.hha = req_tdata[141:111];
      box_in.hwb = req_tdata[252:222];
      box_in.hhb = req_tdata[283:253];
      box_in.dx  = 33'($signed(req_tdata[173:142])) - 33'($signed(req_tdata[31:0]));
      box_in.dy  = 33'($signed(req_tdata[205:174])) - 33'($signed(req_tdata[63:32]));
   end

   orct_sin u_sin_a (.clock(clock), .enable(adv), .angle(req_tdata[79:64]), .sin_out(sa));
   orct_sin u_cos_a (.clock(clock), .enable(adv), .angle(req_tdata[79:64] + quarter),
                     .sin_out(ca));
   orct_sin u_sin_b (.clock(clock), .enable(adv), .angle(req_tdata[221:206]), .sin_out(sb));
   orct_sin u_cos_b (.clock(clock), .enable(adv), .angle(req_tdata[221:206] + quarter),
                     .sin_out(cb));

   always_comb begin
      ax_in[0].x = ca;
      ax_in[0].y = sa;
      ax_in[1].x = -sa;
      ax_in[1].y = ca;
      ax_in[2].x = cb;
      ax_in[2].y = sb;
      ax_in[3].x = -sb;
      ax_in[3].y = cb;
   end

   always_comb begin
      i01     = ($signed(ov_ff[1]) < $signed(ov_ff[0])) ? 2'd1 : 2'd0;
      b01     = ov_ff[i01];
      i23     = ($signed(ov_ff[3]) < $signed(ov_ff[2])) ? 2'd3 : 2'd2;
      b23     = ov_ff[i23];
      bi_in   = ($signed(b23) < $signed(b01)) ? i23 : i01;
      best_in = ov_ff[bi_in];
      hit_in  = (ov_ff[0] > 0) && (ov_ff[1] > 0) && (ov_ff[2] > 0) && (ov_ff[3] > 0);
      flip_in = neg_o_ff[bi_in];
      expos_in = flip_in ? (d0_o_ff[bi_in] < 0) : (d0_o_ff[bi_in] > 0);
      eypos_in = flip_in ? (d1_o_ff[bi_in] < 0) : (d1_o_ff[bi_in] > 0);
   end

   always_comb begin
      nrm = ax_ff[SL+5][bi_s_ff];
      if (flip_s_ff) begin
         nrm.x = -nrm.x;
         nrm.y = -nrm.y;
      end
      nx_in  = orct_pkg::to_q14(nrm.x);
      ny_in  = orct_pkg::to_q14(nrm.y);
      pen_in = (best_s_ff > 38'sh1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : best_s_ff[32:0];
      ex = expos_s_ff ? $signed({1'b0, box_ff[SL+5].hwa}) : -$signed({1'b0, box_ff[SL+5].hwa});
      ey = eypos_s_ff ? $signed({1'b0, box_ff[SL+5].hha}) : -$signed({1'b0, box_ff[SL+5].hha});
   end

   always_comb begin
      cx_in = orct_pkg::sat32(36'(pax_c_ff) + 36'(orct_pkg::rnd_q(64'(cx0_ff)))
                              + 36'(orct_pkg::rnd_q(64'(cx1_ff))));
      cy_in = orct_pkg::sat32(36'(pay_c_ff) + 36'(orct_pkg::rnd_q(64'(cy0_ff)))
                              + 36'(orct_pkg::rnd_q(64'(cy1_ff))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         box_ff[0] <= box_in;
         for (int i = 1; i <= SL+5; i++) begin
            box_ff[i] <= box_ff[i-1];
         end
         ax_ff[SL] <= ax_in;
         for (int i = SL+1; i <= SL+5; i++) begin
            ax_ff[i] <= ax_ff[i-1];
         end

         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
               ppx_ff[k][j] <= $signed(ax_in[k].x) * $signed(ax_in[j].x);
               ppy_ff[k][j] <= $signed(ax_in[k].y) * $signed(ax_in[j].y);
            end
            pdx_ff[k] <= $signed(box_ff[SL-1].dx) * $signed(ax_in[k].x);
            pdy_ff[k] <= $signed(box_ff[SL-1].dy) * $signed(ax_in[k].y);
         end

         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
               dd_ff[k][j] <= 18'(orct_pkg::rnd_q(64'(ppx_ff[k][j])))
                              + 18'(orct_pkg::rnd_q(64'(ppy_ff[k][j])));
            end
            ddf_ff[k] <= 36'(orct_pkg::rnd_q(64'(pdx_ff[k])))
                         + 36'(orct_pkg::rnd_q(64'(pdy_ff[k])));
         end

         for (int k = 0; k < 4; k++) begin
            ht_ff[k][0] <= 48'(box_ff[SL+1].hwa) * 48'(dd_ff[k][0][17] ? -dd_ff[k][0] : dd_ff[k][0]);
            ht_ff[k][1] <= 48'(box_ff[SL+1].hha) * 48'(dd_ff[k][1][17] ? -dd_ff[k][1] : dd_ff[k][1]);
            ht_ff[k][2] <= 48'(box_ff[SL+1].hwb) * 48'(dd_ff[k][2][17] ? -dd_ff[k][2] : dd_ff[k][2]);
            ht_ff[k][3] <= 48'(box_ff[SL+1].hhb) * 48'(dd_ff[k][3][17] ? -dd_ff[k][3] : dd_ff[k][3]);
            adf_h_ff[k] <= 35'(ddf_ff[k][35] ? -ddf_ff[k] : ddf_ff[k]);
            neg_h_ff[k] <= ddf_ff[k][35];
            d0_h_ff[k]  <= dd_ff[k][0];
            d1_h_ff[k]  <= dd_ff[k][1];
         end

         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
               rt_ff[k][j] <= 34'((49'(ht_ff[k][j]) + (49'd1 << (orct_pkg::TRIG_FRAC_BITS - 1)))
                                  >> orct_pkg::TRIG_FRAC_BITS);
            end
            adf_r_ff[k] <= adf_h_ff[k];
            neg_r_ff[k] <= neg_h_ff[k];
            d0_r_ff[k]  <= d0_h_ff[k];
            d1_r_ff[k]  <= d1_h_ff[k];
         end

         for (int k = 0; k < 4; k++) begin
            ov_ff[k] <= $signed(38'(rt_ff[k][0]) + 38'(rt_ff[k][1]) + 38'(rt_ff[k][2])
                                + 38'(rt_ff[k][3]) - 38'(adf_r_ff[k]));
            neg_o_ff[k] <= neg_r_ff[k];
            d0_o_ff[k]  <= d0_r_ff[k];
            d1_o_ff[k]  <= d1_r_ff[k];
         end

         hit_s_ff   <= hit_in;
         bi_s_ff    <= bi_in;
         best_s_ff  <= best_in;
         flip_s_ff  <= flip_in;
         expos_s_ff <= expos_in;
         eypos_s_ff <= eypos_in;

         hit_c_ff <= hit_s_ff;
         nx_c_ff  <= nx_in;
         ny_c_ff  <= ny_in;
         pen_c_ff <= pen_in;
         pax_c_ff <= box_ff[SL+5].pax;
         pay_c_ff <= box_ff[SL+5].pay;
         cx0_ff   <= $signed(ax_ff[SL+5][0].x) * ex;
         cx1_ff   <= $signed(ax_ff[SL+5][1].x) * ey;
         cy0_ff   <= $signed(ax_ff[SL+5][0].y) * ex;
         cy1_ff   <= $signed(ax_ff[SL+5][1].y) * ey;

         hit_out_ff <= hit_c_ff;
         nx_out_ff  <= hit_c_ff ? nx_c_ff : '0;
         ny_out_ff  <= hit_c_ff ? ny_c_ff : '0;
         pen_out_ff <= hit_c_ff ? pen_c_ff : '0;
         cx_out_ff  <= hit_c_ff ? cx_in : '0;
         cy_out_ff  <= hit_c_ff ? cy_in : '0;
      end
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tuser  = hit_out_ff;
   assign rsp_tdata  = {7'd0, cy_out_ff, cx_out_ff, pen_out_ff, ny_out_ff, nx_out_ff};

   `ORCT_ASSERT_IMP(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ORCT_ASSERT_IMP(a_hit_depth, clock, reset, rsp_tvalid && rsp_tuser,
                    rsp_tdata[64:32] != 33'd0)
   `ORCT_ASSERT_NXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(vld_ff[LAST-1]))

endmodule
